[rtl/dsp_pkg.sv]
// ----------------------------------------------------------------------------
// dsp_pkg: shared types and constants for the shortest path engine
// Opcodes, widths, node/edge limits, channel words, controller command and
// status structs.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int MaxNodes   = 64;
  localparam int MaxEdges   = 1024;
  localparam int NodeBits   = 6;
  localparam int CntBits    = 7;
  localparam int EdgeBits   = 10;
  localparam int EcntBits   = 11;
  localparam int WeightBits = 16;
  localparam int DistBits   = 24;

  localparam logic [DistBits-1:0] DistOnes = {DistBits{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_SOLVE = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // Word layouts on the two channels, first field in the MSBs.
  typedef struct packed {
    opcode_t                opcode;
    logic [NodeBits-1:0]    edge_from;
    logic [NodeBits-1:0]    edge_to;
    logic [WeightBits-1:0]  edge_weight;
    logic [NodeBits-1:0]    source_node;
    logic [NodeBits-1:0]    target_node;
  } query_word_t;

  typedef struct packed {
    logic [NodeBits-1:0]    path_node;
    logic [DistBits-1:0]    path_distance;
    logic                   reachable;
    logic                   edges_dropped;
    logic                   last;
  } path_word_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic init;       // start solve: clear settled/reach, seed source
    logic scan_step;  // compare node at scan index
    logic settle;     // mark best node settled, latch it as u
    logic edge_rd;    // issue edge store read at edge index
    logic relax;      // relax edge read last cycle
    logic walk_init;  // start path trace at target
    logic walk_step;  // follow predecessor
    logic emit_load;  // load output register from path stack
  } dsp_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic scan_done;   // scan index reached node limit
    logic found;       // some candidate seen this scan
    logic best_is_dst; // best node equals target
    logic edge_done;   // edge index reached edge count
    logic walk_done;   // path trace complete
    logic emit_done;   // last path entry loaded
    logic bad_query;   // source or target out of range
  } dsp_sts_t;

endpackage

[rtl/dsp_if.sv]
// ----------------------------------------------------------------------------
// dsp_if: ready/valid channel carrying one word
// Generic payload type, source and sink modports.
// ----------------------------------------------------------------------------
interface dsp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/dsp_ctrl.sv]
// ----------------------------------------------------------------------------
// dsp_ctrl: solve sequencer
// One-hot FSM stepping scan, settle, edge sweep, path trace and emission.
// ----------------------------------------------------------------------------
module dsp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,      // solve word accepted
  input  logic            out_free,   // output register may be loaded
  input  dsp_pkg::dsp_sts_t sts,
  output dsp_pkg::dsp_cmd_t cmd,
  output logic            busy,
  output logic            fail        // load unreachable result
);
  import dsp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_INIT   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_EDGE   = 8'b0000_1000,
    S_WALK   = 8'b0001_0000,
    S_EMIT   = 8'b0010_0000,
    S_FAIL   = 8'b0100_0000,
    S_TAIL   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   rd_pend_r, rd_pend_nxt;

  always_comb begin
    state_nxt   = state_r;
    rd_pend_nxt = 1'b0;
    cmd         = '0;
    fail        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_INIT;
      end
      S_INIT: begin
        if (sts.bad_query) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.scan_done) begin
          cmd.scan_step = 1'b1;
        end else if (!sts.found) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.settle = 1'b1;
          state_nxt  = sts.best_is_dst ? S_WALK : S_EDGE;
          cmd.walk_init = sts.best_is_dst;
        end
      end
      S_EDGE: begin
        cmd.relax = rd_pend_r;
        if (!sts.edge_done) begin
          cmd.edge_rd = 1'b1;
          rd_pend_nxt = 1'b1;
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        state_nxt = S_SCAN;   // last relax writes here
      end
      S_WALK: begin
        if (sts.walk_done) state_nxt = S_EMIT;
        else cmd.walk_step = 1'b1;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_done) state_nxt = S_IDLE;
        end
      end
      S_FAIL: begin
        if (out_free) begin
          fail      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

endmodule

[rtl/dsp_dp.sv]
// ----------------------------------------------------------------------------
// dsp_dp: graph stores and solve datapath
// Edge memories, distance/predecessor memories, scan, relax, path stack.
// ----------------------------------------------------------------------------
module dsp_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [dsp_pkg::CntBits-1:0] n_lim,
  input  logic                        op_clear,
  input  logic                        op_add,
  input  logic                        op_solve,
  input  logic [dsp_pkg::NodeBits-1:0]   edge_from,
  input  logic [dsp_pkg::NodeBits-1:0]   edge_to,
  input  logic [dsp_pkg::WeightBits-1:0] edge_weight,
  input  logic [dsp_pkg::NodeBits-1:0]   source_node,
  input  logic [dsp_pkg::NodeBits-1:0]   target_node,
  input  dsp_pkg::dsp_cmd_t           cmd,
  output dsp_pkg::dsp_sts_t           sts,
  output logic [dsp_pkg::NodeBits-1:0] path_node,
  output logic [dsp_pkg::DistBits-1:0] path_distance,
  output logic                        drop,
  output logic                        is_last
);
  import dsp_pkg::*;

  // edge stores
  logic [NodeBits-1:0]   tail_mem [MaxEdges];
  logic [NodeBits-1:0]   head_mem [MaxEdges];
  logic [WeightBits-1:0] cost_mem [MaxEdges];
  logic [EcntBits-1:0]   ecnt_r;
  logic                  drop_r;

  // per-node state
  logic [DistBits-1:0] dist_mem [MaxNodes];
  logic [NodeBits-1:0] pred_mem [MaxNodes];
  logic [MaxNodes-1:0] settled_r, reach_r;

  logic [NodeBits-1:0] src_r, dst_r;
  logic [CntBits-1:0]  idx_r;        // scan index
  logic                found_r;
  logic [DistBits-1:0] best_r;
  logic [NodeBits-1:0] bidx_r;
  logic [NodeBits-1:0] u_r;
  logic [DistBits-1:0] du_r;
  logic [EcntBits-1:0] eidx_r;

  logic [NodeBits-1:0]   et_q, eh_q;
  logic [WeightBits-1:0] ec_q;

  // scan compare stage
  logic                cmp_v_r;
  logic [NodeBits-1:0] cidx_r;
  logic [DistBits-1:0] dq_r;         // registered distance read

  // relax second stage
  logic                v2_r, ok2_r;
  logic [NodeBits-1:0] eh2_r;
  logic [DistBits-1:0] sum2_r;

  // path stack
  logic [NodeBits-1:0] stk_mem [MaxNodes];
  logic [CntBits-1:0]  sp_r;
  logic [NodeBits-1:0] wv_r;
  logic                wdone_r;
  logic [DistBits-1:0] pdist_r;
  logic [NodeBits-1:0] pn_q;         // registered stack top

  logic add_ok;
  assign add_ok = ({1'b0, edge_from} < n_lim) && ({1'b0, edge_to} < n_lim)
                  && (ecnt_r < EcntBits'(MaxEdges));

  always_ff @(posedge clk) begin
    if (op_add && add_ok) begin
      tail_mem[ecnt_r[EdgeBits-1:0]] <= edge_from;
      head_mem[ecnt_r[EdgeBits-1:0]] <= edge_to;
      cost_mem[ecnt_r[EdgeBits-1:0]] <= edge_weight;
    end
    if (cmd.edge_rd) begin
      et_q <= tail_mem[eidx_r[EdgeBits-1:0]];
      eh_q <= head_mem[eidx_r[EdgeBits-1:0]];
      ec_q <= cost_mem[eidx_r[EdgeBits-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecnt_r <= '0;
      drop_r <= 1'b0;
    end else if (op_clear) begin
      ecnt_r <= '0;
      drop_r <= 1'b0;
    end else if (op_add) begin
      if (add_ok) ecnt_r <= ecnt_r + 1'b1;
      else drop_r <= 1'b1;
    end
  end

  // one registered distance read per cycle: scan node or relaxed edge head;
  // scan and relax never overlap.
  logic [NodeBits-1:0] rd_addr;
  logic                scan_go;
  assign rd_addr = cmd.relax ? eh_q : idx_r[NodeBits-1:0];
  assign scan_go = cmd.scan_step && (idx_r != n_lim);

  logic cand;
  assign cand = cmp_v_r && reach_r[cidx_r] && !settled_r[cidx_r];

  // relax: stage 1 sums and checks the edge, stage 2 compares and writes
  logic [DistBits:0]   sum_w;
  logic [DistBits-1:0] sum_s;
  logic                rel_ok, rel_wr;
  assign sum_w  = {1'b0, du_r} + {{(DistBits+1-WeightBits){1'b0}}, ec_q};
  assign sum_s  = sum_w[DistBits] ? DistOnes : sum_w[DistBits-1:0];
  assign rel_ok = (et_q == u_r) && ({1'b0, eh_q} < n_lim) && !settled_r[eh_q];
  assign rel_wr = v2_r && ok2_r && (!reach_r[eh2_r] || sum2_r < dq_r);

  always_ff @(posedge clk) begin
    if (cmd.init) dist_mem[src_r] <= '0;
    else if (rel_wr) begin
      dist_mem[eh2_r] <= sum2_r;
      pred_mem[eh2_r] <= u_r;
    end
    // a write to the address read this cycle is passed straight through
    if (rel_wr && eh2_r == rd_addr) dq_r <= sum2_r;
    else dq_r <= dist_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      cmp_v_r <= scan_go;
      v2_r    <= cmd.relax;
    end
  end

  logic [NodeBits-1:0] top;
  assign top = sp_r[NodeBits-1:0] - (cmd.emit_load ? NodeBits'(2) : NodeBits'(1));

  always_ff @(posedge clk) begin
    if (op_solve) begin
      src_r <= source_node;
      dst_r <= target_node;
    end
    if (cmd.init) begin
      settled_r <= '0;
      reach_r   <= {{(MaxNodes-1){1'b0}}, 1'b1} << src_r;
      idx_r   <= '0;
      found_r <= 1'b0;
    end
    if (scan_go) begin
      idx_r  <= idx_r + 1'b1;
      cidx_r <= idx_r[NodeBits-1:0];
    end
    if (cand && (!found_r || dq_r < best_r)) begin
      found_r <= 1'b1;
      best_r  <= dq_r;
      bidx_r  <= cidx_r;
    end
    if (cmd.relax) begin
      ok2_r  <= rel_ok;
      eh2_r  <= eh_q;
      sum2_r <= sum_s;
    end
    if (cmd.settle) begin
      settled_r[bidx_r] <= 1'b1;
      u_r     <= bidx_r;
      du_r    <= best_r;
      eidx_r  <= '0;
      idx_r   <= '0;
      found_r <= 1'b0;
    end
    if (cmd.edge_rd) eidx_r <= eidx_r + 1'b1;
    if (rel_wr) reach_r[eh2_r] <= 1'b1;
    if (cmd.walk_init) begin
      wv_r    <= dst_r;
      sp_r    <= '0;
      wdone_r <= 1'b0;
      pdist_r <= best_r;
    end
    if (cmd.walk_step) begin
      stk_mem[sp_r[NodeBits-1:0]] <= wv_r;
      sp_r <= sp_r + 1'b1;
      if (wv_r == src_r || sp_r + 1'b1 == n_lim) wdone_r <= 1'b1;
      else wv_r <= pred_mem[wv_r];
    end
    if (cmd.emit_load) sp_r <= sp_r - 1'b1;
    pn_q <= stk_mem[top];
  end

  assign path_node     = pn_q;
  assign path_distance = pdist_r;
  assign is_last       = (sp_r == CntBits'(1));
  assign drop          = drop_r;

  assign sts.scan_done   = (idx_r == n_lim) && !cmp_v_r;
  assign sts.found       = found_r;
  assign sts.best_is_dst = (bidx_r == dst_r);
  assign sts.edge_done   = (eidx_r == ecnt_r);
  assign sts.walk_done   = wdone_r;
  assign sts.emit_done   = is_last;
  assign sts.bad_query   = ({1'b0, src_r} >= n_lim) || ({1'b0, dst_r} >= n_lim);

endmodule

[rtl/dijkstra_shortest_path_target.sv]
// ----------------------------------------------------------------------------
// dijkstra_shortest_path_target: single-pair shortest path engine
// Stores a directed weighted graph and answers source/target path queries.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | word
//  in      | in  | valid/ready       | opcode, edges, query nodes
//  out     | out | valid/ready       | path node, distance, flags, last
//  cfg     | in  | we, no backpress  | nodes_in_use
//
//  Clear and add-edge words are accepted back to back.
//  A solve: a setup state, then rounds; each round scans the n nodes
//  (registered reads, one compare stage, settle); a round that does not
//  settle the target adds a sweep over the stored edges, one edge per cycle.
//  Then a path trace, and one emitted word per path node.
//  Reset (rst_n low, synchronous) empties the graph; nodes_in_use = 64.
//  A stalled output holds the sequencer; input is not taken while solving.
// ----------------------------------------------------------------------------
module dijkstra_shortest_path_target (
  input  logic       clk,
  input  logic       rst_n,
  dsp_if.sink        in_ch,
  dsp_if.source      out_ch,
  input  logic       cfg_we,
  input  logic [6:0] cfg_nodes_in_use
);
  import dsp_pkg::*;

  logic [CntBits-1:0] cfg_r, n_lim;
  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= CntBits'(MaxNodes);
    else if (cfg_we) cfg_r <= cfg_nodes_in_use;
  end
  // clamp to 1..MaxNodes
  assign n_lim = (cfg_r == '0) ? CntBits'(1) :
                 (cfg_r > CntBits'(MaxNodes)) ? CntBits'(MaxNodes) : cfg_r;

  logic busy, fail, out_free, acc;
  dsp_cmd_t cmd;
  dsp_sts_t sts;
  logic [1:0] op;

  assign in_ch.ready = !busy;
  assign acc = in_ch.valid && in_ch.ready;
  assign op  = in_ch.data.opcode;

  logic [NodeBits-1:0] pn;
  logic [DistBits-1:0] pd;
  logic drop, lst;

  dsp_ctrl u_ctrl (
    .clk, .rst_n,
    .start    (acc && op == OP_SOLVE),
    .out_free (out_free),
    .sts, .cmd, .busy, .fail
  );

  dsp_dp u_dp (
    .clk, .rst_n, .n_lim,
    .op_clear    (acc && op == OP_CLEAR),
    .op_add      (acc && op == OP_ADD),
    .op_solve    (acc && op == OP_SOLVE),
    .edge_from   (in_ch.data.edge_from),
    .edge_to     (in_ch.data.edge_to),
    .edge_weight (in_ch.data.edge_weight),
    .source_node (in_ch.data.source_node),
    .target_node (in_ch.data.target_node),
    .cmd, .sts,
    .path_node (pn), .path_distance (pd), .drop, .is_last (lst)
  );

  // output register
  logic ov_r;
  assign out_free = !ov_r || out_ch.ready;
  assign out_ch.valid = ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.emit_load || fail) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_ch.data.path_node     <= pn;
      out_ch.data.path_distance <= pd;
      out_ch.data.reachable     <= 1'b1;
      out_ch.data.edges_dropped <= drop;
      out_ch.data.last          <= lst;
    end else if (fail) begin
      out_ch.data.path_node     <= '0;
      out_ch.data.path_distance <= DistOnes;
      out_ch.data.reachable     <= 1'b0;
      out_ch.data.edges_dropped <= drop;
      out_ch.data.last          <= 1'b1;
    end
  end

endmodule

[dv/dijkstra_shortest_path_target_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dijkstra_shortest_path_target_test: shortest path engine testbench
// Builds graphs through clear/add-edge words, runs solves and checks every
// emitted path word against a built-in Dijkstra predictor, under random
// idling on both channels and several node-count settings.
// ----------------------------------------------------------------------------
module dijkstra_shortest_path_target_test;
  import dsp_pkg::*;

  // Graph mirror plus a queue of path words still owed by the block.
  class path_scoreboard;
    logic [NodeBits-1:0]   tail_q[MaxEdges];
    logic [NodeBits-1:0]   head_q[MaxEdges];
    logic [WeightBits-1:0] cost_q[MaxEdges];
    int                    edge_total;
    bit                    dropped;
    int                    node_count;
    path_word_t            owed[$];
    int                    errors;
    int                    words_seen;
    int                    solves;

    function new();
      edge_total = 0;
      dropped    = 0;
      node_count = 64;
      errors     = 0;
      words_seen = 0;
      solves     = 0;
    endfunction

    function int live_nodes();
      if (node_count < 1) return 1;
      if (node_count > MaxNodes) return MaxNodes;
      return node_count;
    endfunction

    function void owe(int node, longint total, bit reach, bit fin);
      path_word_t w;
      w.path_node     = node[NodeBits-1:0];
      w.path_distance = total[DistBits-1:0];
      w.reachable     = reach;
      w.edges_dropped = dropped;
      w.last          = fin;
      owed = {owed, w};
    endfunction

    // Linear-scan Dijkstra, stops once the target settles.
    function void predict_path(int src, int dst);
      int     n, best_node, len, v, h;
      longint best, sum;
      bit     found, reached;
      longint tent[MaxNodes];
      int     pred[MaxNodes];
      bit     done[MaxNodes];
      int     trail[MaxNodes];
      n = live_nodes();
      solves++;
      if (src >= n || dst >= n) begin
        owe(0, DistOnes, 0, 1);
        return;
      end
      for (int i = 0; i < MaxNodes; i++) begin
        tent[i] = DistOnes;
        pred[i] = 127;
        done[i] = 0;
      end
      tent[src] = 0;
      forever begin
        found = 0;
        best = 0;
        best_node = 0;
        for (int i = 0; i < n; i++) begin
          reached = (i == src) || (pred[i] != 127);
          if (!reached || done[i]) continue;
          if (!found || tent[i] < best) begin
            found = 1;
            best = tent[i];
            best_node = i;
          end
        end
        if (!found) begin
          owe(0, DistOnes, 0, 1);
          return;
        end
        done[best_node] = 1;
        if (best_node == dst) break;
        for (int e = 0; e < edge_total; e++) begin
          if (tail_q[e] != best_node) continue;
          h = head_q[e];
          if (h >= n || done[h]) continue;
          sum = tent[best_node] + cost_q[e];
          if (sum > DistOnes) sum = DistOnes;
          reached = (h == src) || (pred[h] != 127);
          if (!reached || sum < tent[h]) begin
            tent[h] = sum;
            pred[h] = best_node;
          end
        end
      end
      len = 0;
      v = dst;
      while (len < n) begin
        trail[len++] = v;
        if (v == src || pred[v] == 127) break;
        v = pred[v];
        if (v >= n) break;
      end
      for (int k = 0; k < len; k++)
        owe(trail[len-1-k], tent[dst], 1, k + 1 == len);
    endfunction

    function void note_query(query_word_t q);
      int n;
      n = live_nodes();
      case (q.opcode)
        OP_CLEAR: begin
          edge_total = 0;
          dropped = 0;
        end
        OP_ADD: begin
          if (q.edge_from >= n || q.edge_to >= n || edge_total >= MaxEdges) begin
            dropped = 1;
          end else begin
            tail_q[edge_total] = q.edge_from;
            head_q[edge_total] = q.edge_to;
            cost_q[edge_total] = q.edge_weight;
            edge_total++;
          end
        end
        OP_SOLVE: predict_path(q.source_node, q.target_node);
        default: ;
      endcase
    endfunction

    function void check_path(path_word_t got);
      path_word_t want;
      words_seen++;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected path word %p", got);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("path word mismatch: expected node %0d dist %h reach %b drop %b last %b,",
                   want.path_node, want.path_distance, want.reachable,
                   want.edges_dropped, want.last,
                   " got node %0d dist %h reach %b drop %b last %b",
                   got.path_node, got.path_distance, got.reachable,
                   got.edges_dropped, got.last);
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 40000;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       cfg_we = 0;
  logic [6:0] cfg_nodes_in_use = 7'd64;

  dsp_if #(.payload_t(query_word_t)) in_ch ();
  dsp_if #(.payload_t(path_word_t))  out_ch ();

  dijkstra_shortest_path_target dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch.sink),
    .out_ch           (out_ch.source),
    .cfg_we           (cfg_we),
    .cfg_nodes_in_use (cfg_nodes_in_use)
  );

  path_scoreboard sb = new();

  bit calm = 0;          // no idling on either side in the closing stretch
  int words_sent = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Receiver: ready drops in random bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else if (calm) begin
      out_ch.ready <= 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= 1;
    end
  end

  // Result monitor and watchdog on idle cycles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_path(out_ch.data);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(query_word_t w);
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_query(w);
    words_sent++;
  endtask

  task automatic send_op(opcode_t op, int a = 0, int b = 0, int wt = 0);
    query_word_t w;
    w = '0;
    w.opcode = op;
    if (op == OP_SOLVE) begin
      w.source_node = NodeBits'(a);
      w.target_node = NodeBits'(b);
    end else begin
      w.edge_from   = NodeBits'(a);
      w.edge_to     = NodeBits'(b);
      w.edge_weight = WeightBits'(wt);
    end
    send_word(w);
  endtask

  // Sender holds off until every owed path word has arrived.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_nodes(int value);
    drain();
    @(negedge clk);
    cfg_we <= 1;
    cfg_nodes_in_use <= 7'(value);
    @(negedge clk);
    cfg_we <= 0;
    sb.node_count = value;
  endtask

  // Random graph over n nodes, mostly in range, then a few solves.
  task automatic random_round(int n, int edges, int queries);
    query_word_t w;
    logic [63:0] rnd;
    send_op(OP_CLEAR);
    for (int i = 0; i < edges; i++) begin
      w = '0;
      w.opcode = OP_ADD;
      w.edge_weight = WeightBits'($urandom());
      if ($urandom_range(0, 3) == 0)
        w.edge_weight = WeightBits'($urandom_range(0, 3) << 8);
      if ($urandom_range(0, 19) == 0) begin
        w.edge_from = NodeBits'($urandom());
        w.edge_to   = NodeBits'($urandom());
      end else begin
        w.edge_from = NodeBits'($urandom_range(0, n - 1));
        w.edge_to   = NodeBits'($urandom_range(0, n - 1));
      end
      w.source_node = NodeBits'($urandom());
      w.target_node = NodeBits'($urandom());
      send_word(w);
    end
    for (int i = 0; i < queries; i++) begin
      rnd = {$urandom(), $urandom()};
      w = rnd[$bits(query_word_t)-1:0];
      w.opcode = ($urandom_range(0, 15) == 0) ? OP_NONE : OP_SOLVE;
      if ($urandom_range(0, 9) != 0) begin
        w.source_node = NodeBits'($urandom_range(0, n - 1));
        w.target_node = NodeBits'($urandom_range(0, n - 1));
      end
      send_word(w);
    end
  endtask

  initial begin
    int n;
    in_ch.valid = 0;
    in_ch.data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: a small chain, a shortcut that loses, extremes of fields.
    send_op(OP_ADD, 0, 1, 16'h0100);
    send_op(OP_ADD, 1, 2, 16'h0080);
    send_op(OP_ADD, 0, 2, 16'hFFFF);
    send_op(OP_ADD, 63, 0, 16'h0000);
    send_op(OP_ADD, 2, 63, 16'h0001);
    send_op(OP_SOLVE, 0, 2);
    send_op(OP_SOLVE, 63, 63);   // source equals target
    send_op(OP_SOLVE, 63, 63);
    send_op(OP_SOLVE, 2, 0);     // reached through node 63
    send_op(OP_SOLVE, 63, 2);
    send_op(OP_NONE, 5, 6, 16'hFFFF);
    send_op(OP_SOLVE, 1, 0);

    // Lower the node count: stored edges beyond it are skipped, new ones beyond it drop.
    set_nodes(3);
    send_op(OP_SOLVE, 0, 2);
    send_op(OP_SOLVE, 0, 5);     // target out of range
    send_op(OP_SOLVE, 7, 0);     // source out of range
    send_op(OP_ADD, 3, 0, 16'h0100);
    send_op(OP_SOLVE, 0, 1);     // drop flag now set
    set_nodes(1);
    send_op(OP_SOLVE, 0, 0);
    send_op(OP_SOLVE, 0, 1);
    set_nodes(0);                // clamps to one node
    send_op(OP_SOLVE, 0, 0);
    send_op(OP_CLEAR);
    send_op(OP_SOLVE, 0, 0);
    set_nodes(127);              // clamps to the maximum
    send_op(OP_SOLVE, 63, 63);

    // Random rounds over several node counts; the last ones run without idling.
    while (words_sent < 350) begin
      case ($urandom_range(0, 5))
        0:       n = 64;
        1:       n = 2;
        default: n = $urandom_range(2, 12);
      endcase
      if (words_sent > 280) calm = 1;
      set_nodes(n);
      random_round(n, (n == 64) ? $urandom_range(20, 60) : $urandom_range(0, 3 * n),
                   $urandom_range(2, 6));
    end
    calm = 1;
    drain();
    @(negedge clk);
    in_ch.valid <= 0;
    repeat (100) @(posedge clk);

    $display("Sent %0d input words, %0d solves, %0d path words checked.",
             words_sent, sb.solves, sb.words_seen);
    $display("Node counts from 0 to 127 written, drops and out-of-range queries hit.");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d path words never arrived", sb.errors, sb.owed.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/dsp_pkg.sv
rtl/dsp_if.sv
rtl/dsp_ctrl.sv
rtl/dsp_dp.sv
rtl/dijkstra_shortest_path_target.sv
dv/dijkstra_shortest_path_target_test.sv
